// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define TSAR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tsar assertion failed");

// Next-cycle implication
`define TSAR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tsar assertion failed");

`endif

// ===== src/tsar_pkg.sv =====
// Shared types and constants of the TCP SYN-ACK reply detector.
// No dependencies; imported by tsar_hdr_track and tcp_syn_ack_reply_detector.
package tsar_pkg;

	// One input item: a packet byte and its end-of-packet mark
	typedef struct packed {
		logic [7:0] packet_byte;
		logic       last_byte;
	} tsar_byte_t;

	// One result item
	typedef struct packed {
		logic        port_open;
		logic [15:0] port_number;
	} tsar_result_t;

	localparam logic [7:0] TCP_PROTOCOL  = 8'd6;
	localparam logic [5:0] MIN_HDR_LEN   = 6'd20;
	localparam logic [6:0] POS_MAX       = 7'd127;
	localparam logic [6:0] POS_PROTOCOL  = 7'd9;
	localparam logic [6:0] POS_SRC_FIRST = 7'd12;
	localparam logic [6:0] POS_SRC_LAST  = 7'd15;
	localparam logic [6:0] FLAGS_OFFSET  = 7'd13;
	localparam int         FLAG_SYN_BIT  = 1;
	localparam int         FLAG_ACK_BIT  = 4;

endpackage

// ===== src/tsar_in_if.sv =====
// Input channel: packet bytes with valid/ready handshake.
// Standalone; used by the top level of the detector.
interface tsar_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] packet_byte;
	logic       last_byte;

	modport source (output valid, packet_byte, last_byte, input ready);
	modport sink   (input valid, packet_byte, last_byte, output ready);
endinterface

// ===== src/tsar_out_if.sv =====
// Result channel: match flag and TCP source port with valid/ready handshake.
// Standalone; used by the top level of the detector.
interface tsar_out_if;
	logic        valid;
	logic        ready;
	logic        port_open;
	logic [15:0] port_number;

	modport source (output valid, port_open, port_number, input ready);
	modport sink   (input valid, port_open, port_number, output ready);
endinterface

// ===== src/tsar_hdr_track.sv =====
// Per-packet header tracker: position, IHL, protocol, address compare, port and flags.
// Depends on tsar_pkg. Updates its state once per stepped byte and clears on the last byte.
module tsar_hdr_track (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  tsar_pkg::tsar_byte_t  item,
	input  logic [31:0]           target,
	output tsar_pkg::tsar_result_t result
);
	import tsar_pkg::*;

	logic [6:0]  pos_q;
	logic [5:0]  hdr_len_q;
	logic        is_tcp_q;
	logic        addr_eq_q;
	logic [15:0] src_port_q;
	logic        syn_ack_q;

	logic [5:0]  hdr_len_d;
	logic        is_tcp_d;
	logic        addr_eq_d;
	logic [15:0] src_port_d;
	logic        syn_ack_d;
	logic [6:0]  hl7;
	logic        hdr_ok;
	logic        in_capture;
	logic        in_src;
	logic [7:0]  want;
	logic        port_full;
	logic [7:0]  b;

	// Compute the state after this byte
	always_comb begin
		b         = item.packet_byte;
		hdr_len_d = (pos_q == '0) ? {b[3:0], 2'b00} : hdr_len_q;
		is_tcp_d  = (pos_q == POS_PROTOCOL) ? (b == TCP_PROTOCOL) : is_tcp_q;

		// Pick the target byte for this address position, first byte most significant
		case (pos_q[1:0])
			2'd0:    want = target[31:24];
			2'd1:    want = target[23:16];
			2'd2:    want = target[15:8];
			default: want = target[7:0];
		endcase
		in_src    = (pos_q >= POS_SRC_FIRST) && (pos_q <= POS_SRC_LAST);
		addr_eq_d = addr_eq_q && !(in_src && (b != want));

		hl7        = {1'b0, hdr_len_d};
		hdr_ok     = (hdr_len_d >= MIN_HDR_LEN);
		in_capture = hdr_ok && (pos_q != POS_MAX);
		src_port_d = src_port_q;
		syn_ack_d  = syn_ack_q;
		if (in_capture) begin
			if (pos_q == hl7) begin
				src_port_d = {b, 8'h00};
			end else if (pos_q == hl7 + 7'd1) begin
				src_port_d = {src_port_q[15:8], b};
			end else if (pos_q == hl7 + FLAGS_OFFSET) begin
				syn_ack_d = b[FLAG_SYN_BIT] && b[FLAG_ACK_BIT];
			end
		end

		port_full          = hdr_ok && (pos_q >= hl7 + 7'd1);
		result.port_open   = hdr_ok && is_tcp_d && addr_eq_d && syn_ack_d &&
			(pos_q >= POS_SRC_LAST);
		result.port_number = port_full ? src_port_d : 16'h0000;
	end

	// Advance on each byte; clear back to the packet start on the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			hdr_len_q  <= '0;
			is_tcp_q   <= 1'b0;
			addr_eq_q  <= 1'b1;
			src_port_q <= '0;
			syn_ack_q  <= 1'b0;
		end else if (step) begin
			if (item.last_byte) begin
				pos_q      <= '0;
				hdr_len_q  <= '0;
				is_tcp_q   <= 1'b0;
				addr_eq_q  <= 1'b1;
				src_port_q <= '0;
				syn_ack_q  <= 1'b0;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 7'd1;
				end
				hdr_len_q  <= hdr_len_d;
				is_tcp_q   <= is_tcp_d;
				addr_eq_q  <= addr_eq_d;
				src_port_q <= src_port_d;
				syn_ack_q  <= syn_ack_d;
			end
		end
	end

endmodule

// ===== src/tcp_syn_ack_reply_detector.sv =====
// Channel  Dir  Payload                          Handshake
// pkt      in   packet_byte[8], last_byte[1]     valid/ready
// reply    out  port_open[1], port_number[16]    valid/ready
// target   cfg  target_wdata[32]                 target_we
//
// One byte per cycle unless a last byte waits on a stalled result: an input register
// feeds the header tracker; its last-byte result is loaded into the output register.
// Reset (arst_n low) clears the pipeline valids, the tracker state and the target.
// A stalled result holds only a last byte in the input register; other bytes flow on.
// Depends on tsar_pkg, tsar_in_if, tsar_out_if and tsar_hdr_track.
module tcp_syn_ack_reply_detector (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        target_we,
	input  logic [31:0] target_wdata,
	tsar_in_if.sink     pkt,
	tsar_out_if.source  reply
);
	import tsar_pkg::*;

	logic         valid_s1;
	tsar_byte_t   item_s1;
	logic [31:0]  target_q;
	logic         out_valid_q;
	tsar_result_t out_q;
	tsar_result_t result;
	logic         out_free;
	logic         consume;

	// Hold the target address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (target_we) begin
			target_q <= target_wdata;
		end
	end

	// A last byte waits for room in the output register
	assign out_free  = !out_valid_q || reply.ready;
	assign consume   = valid_s1 && (!item_s1.last_byte || out_free);
	assign pkt.ready = !valid_s1 || consume;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			valid_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			item_s1 <= '{packet_byte: pkt.packet_byte, last_byte: pkt.last_byte};
		end
	end

	tsar_hdr_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (consume),
		.item   (item_s1),
		.target (target_q),
		.result (result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume && item_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (reply.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && item_s1.last_byte) begin
			out_q <= result;
		end
	end

	assign reply.valid       = out_valid_q;
	assign reply.port_open   = out_q.port_open;
	assign reply.port_number = out_q.port_number;

endmodule

// ===== src/tsar_checker.sv =====
// Port-level checks of the detector's handshakes and result timing.
// Depends on assert_macros.svh; bound to tcp_syn_ack_reply_detector below.
`include "assert_macros.svh"

module tsar_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pkt_valid,
	input logic        pkt_ready,
	input logic        pkt_last,
	input logic        reply_valid,
	input logic        reply_ready,
	input logic        reply_port_open,
	input logic [15:0] reply_port_number
);

	// A stalled result stays offered
	`TSAR_ASSERT_NXT(a_reply_hold, reply_valid && !reply_ready, reply_valid)

	// A stalled result keeps its payload
	`TSAR_ASSERT_NXT(a_reply_stable, reply_valid && !reply_ready, $stable(reply_port_open) && $stable(reply_port_number))

	// A fresh result must trace back to a last byte taken at the input
	`TSAR_ASSERT_IMP(a_reply_origin, $rose(reply_valid), $past(pkt_valid && pkt_ready && pkt_last, 2))

	// With no result pending the input is always open
	`TSAR_ASSERT_IMP(a_in_open, !reply_valid, pkt_ready)

endmodule

bind tcp_syn_ack_reply_detector tsar_checker u_tsar_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.pkt_valid         (pkt.valid),
	.pkt_ready         (pkt.ready),
	.pkt_last          (pkt.last_byte),
	.reply_valid       (reply.valid),
	.reply_ready       (reply.ready),
	.reply_port_open   (reply.port_open),
	.reply_port_number (reply.port_number)
);
